>>> sv/cuofp_pkg.sv
// Package with the item types and codes shared by the CAN-over-UDP frame parser.
`timescale 1ns / 1ps

package cuofp_pkg;

  // Number of header bytes at the start of every datagram.
  localparam int unsigned HeaderBytes = 5;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes.
  localparam logic ErrShort = 1'b0;
  localparam logic ErrTrunc = 1'b1;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        message_last;
    logic [31:0] frame_id;
    logic [7:0]  payload_length;
    logic [15:0] message_index;
    logic [7:0]  version_field;
    logic [7:0]  opcode_field;
    logic [7:0]  sequence_number;
    logic [15:0] message_count;
    logic        error_code;
    logic        run_last;
  } out_item_t;

  // Queue entry: the first result of an input item, and whether a
  // truncation error follows it.
  typedef struct packed {
    out_item_t res;
    logic      second;
  } rec_t;

endpackage

>>> sv/cuofp_front.sv
// Front part: takes datagram bytes, tracks the parse state and builds result records.
`timescale 1ns / 1ps

module cuofp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cuofp_pkg::in_item_t in_item_i,
  input  logic               full_i,
  output logic               push_o,
  output cuofp_pkg::rec_t    rec_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_MESSAGE = 2'd1,
    PH_IGNORE  = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  opc_q, opc_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] done_q, done_d;
  logic [31:0] id_q, id_d;
  logic [7:0]  len_q, len_d;

  logic        accept;
  logic        has_res;
  logic        last;
  logic [2:0]  hpos;
  logic [7:0]  db;
  logic        eod;

  assign accept = in_valid_i && !full_i;
  assign db     = in_item_i.data_byte;
  assign eod    = in_item_i.end_of_datagram;
  assign push_o = accept && has_res;

  // Header position saturates at the last header byte.
  assign hpos = (pos_q > 9'(cuofp_pkg::HeaderBytes - 1)) ?
                3'(cuofp_pkg::HeaderBytes - 1) : pos_q[2:0];

  // Next state and the result record for the byte on the input.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    ver_d   = ver_q;
    opc_d   = opc_q;
    seq_d   = seq_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    id_d    = id_q;
    len_d   = len_q;
    has_res = 1'b0;
    last    = 1'b0;
    rec_o   = '0;
    unique case (phase_q)
      PH_HEADER: begin
        if (hpos == 3'd0) begin
          ver_d = db;
          opc_d = '0;
          seq_d = '0;
          cnt_d = '0;
        end else if (hpos == 3'd1) begin
          opc_d = db;
        end else if (hpos == 3'd2) begin
          seq_d = db;
        end else if (hpos == 3'd3) begin
          cnt_d = {db, 8'h00};
        end else begin
          cnt_d = {cnt_q[15:8], db};
        end
        if (hpos < 3'(cuofp_pkg::HeaderBytes - 1)) begin
          if (eod) begin
            has_res              = 1'b1;
            rec_o.res.kind       = cuofp_pkg::KIND_ERROR;
            rec_o.res.error_code = cuofp_pkg::ErrShort;
            pos_d                = '0;
          end else begin
            pos_d = 9'(hpos) + 9'd1;
          end
        end else begin
          has_res        = 1'b1;
          rec_o.res.kind = cuofp_pkg::KIND_HEADER;
          done_d         = '0;
          id_d           = '0;
          len_d          = '0;
          pos_d          = '0;
          if (eod) begin
            phase_d = PH_HEADER;
          end else if (cnt_d == 16'd0) begin
            phase_d = PH_IGNORE;
          end else begin
            phase_d = PH_MESSAGE;
          end
        end
      end
      PH_MESSAGE: begin
        has_res                 = 1'b1;
        rec_o.res.kind          = cuofp_pkg::KIND_BYTE;
        rec_o.res.out_byte      = db;
        rec_o.res.message_index = done_q;
        if (pos_q < 9'd4) begin
          id_d = (pos_q == 9'd0) ? {24'h000000, db} : {id_q[23:0], db};
        end else begin
          if (pos_q == 9'd4) begin
            len_d = db;
            last  = (db == 8'd0);
          end else begin
            last = ((pos_q - 9'd4) >= {1'b0, len_q});
          end
          rec_o.res.message_last   = last;
          rec_o.res.frame_id       = id_q;
          rec_o.res.payload_length = len_d;
          rec_o.second             = eod && !last;
        end
        if (last) begin
          done_d = done_q + 16'd1;
          pos_d  = '0;
          if (done_d == cnt_q) begin
            phase_d = PH_IGNORE;
          end
        end else begin
          pos_d = pos_q + 9'd1;
        end
        if (eod) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
        end
      end
      default: begin
        if (eod) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
        end
      end
    endcase
    // Header fields travel on every result.
    rec_o.res.version_field   = ver_d;
    rec_o.res.opcode_field    = opc_d;
    rec_o.res.sequence_number = seq_d;
    rec_o.res.message_count   = cnt_d;
    rec_o.res.run_last        = !rec_o.second;
  end

  // Parse state, updated on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      ver_q   <= '0;
      opc_q   <= '0;
      seq_q   <= '0;
      cnt_q   <= '0;
      done_q  <= '0;
      id_q    <= '0;
      len_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ver_q   <= ver_d;
      opc_q   <= opc_d;
      seq_q   <= seq_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      id_q    <= id_d;
      len_q   <= len_d;
    end
  end

endmodule

>>> sv/cuofp_queue.sv
// Short queue of result records between the front and the back.
`timescale 1ns / 1ps

module cuofp_queue #(
  parameter int unsigned Depth = cuofp_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cuofp_pkg::rec_t rec_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            nonempty_o,
  output cuofp_pkg::rec_t rec_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cuofp_pkg::rec_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign nonempty_o = (count_q != '0);
  assign rec_o      = entries_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

>>> sv/cuofp_back.sv
// Back part: turns queued records into result items on the output register.
`timescale 1ns / 1ps

module cuofp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 nonempty_i,
  input  cuofp_pkg::rec_t      rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output cuofp_pkg::out_item_t out_item_o,
  input  logic                 out_stall_i
);

  cuofp_pkg::out_item_t out_q;
  logic                 valid_q;
  logic                 pend_q;
  logic                 load;

  assign load        = !valid_q || !out_stall_i;
  assign pop_o       = load && !pend_q && nonempty_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = out_q;

  // Output control: a pending truncation error goes out before the next record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else if (nonempty_i) begin
        valid_q <= 1'b1;
        pend_q  <= rec_i.second;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload; the error keeps the message fields of the byte before it.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_q.kind         <= cuofp_pkg::KIND_ERROR;
        out_q.out_byte     <= '0;
        out_q.message_last <= 1'b0;
        out_q.error_code   <= cuofp_pkg::ErrTrunc;
        out_q.run_last     <= 1'b1;
      end else if (nonempty_i) begin
        out_q <= rec_i.res;
      end
    end
  end

endmodule

>>> sv/can_over_udp_frame_parser_unit.sv
// Top level of the CAN-over-UDP frame parser.
`timescale 1ns / 1ps

// Parses a CAN-over-UDP datagram presented one byte per item and accepts one
// byte every clock cycle while the queue has room. The front stage updates the
// header and message counters in the cycle a byte is accepted and queues at most
// one record per byte; the back stage moves records to the output register at
// one result per cycle while the output is not stalled, so a byte that ends a
// datagram inside a payload yields two results, the byte and a truncation error.
// A result passes through the record queue and then the output register. Input
// stall rises only when the record queue (QueueDepth entries) is full, which
// happens only while the output is stalled or after a burst of truncation errors.
module can_over_udp_frame_parser_unit #(
  parameter int unsigned QueueDepth = cuofp_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  cuofp_pkg::in_item_t  in_item_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output cuofp_pkg::out_item_t out_item_o,
  input  logic                 out_stall_i
);

  logic            push;
  logic            pop;
  logic            full;
  logic            nonempty;
  cuofp_pkg::rec_t rec_in;
  cuofp_pkg::rec_t rec_out;

  assign in_stall_o = full;

  cuofp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  cuofp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rec_i      (rec_in),
    .pop_i      (pop),
    .full_o     (full),
    .nonempty_o (nonempty),
    .rec_o      (rec_out)
  );

  cuofp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the CAN-over-UDP frame parser.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IdBytes     = 4;
  localparam int unsigned LiveItems   = 1400;
  localparam int unsigned IdlePercent = 21;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 400000;

  // Parser phases as the shadow parser tracks them.
  typedef enum logic [1:0] {
    PARSE_HEADER  = 2'd0,
    PARSE_MESSAGE = 2'd1,
    PARSE_SKIP    = 2'd2
  } parse_state_e;

  // One row of the directed table: the byte to send and, where it is obvious,
  // the single result typed in by hand.
  typedef struct {
    cuofp_pkg::in_item_t  stim;
    bit                   pinned;
    cuofp_pkg::out_item_t want;
  } drill_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  cuofp_pkg::in_item_t  in_item   = '0;
  logic                 in_stall;
  logic                 out_valid;
  cuofp_pkg::out_item_t out_item;
  logic                 out_stall = 1'b0;

  // Shadow parser state.
  parse_state_e parse_phase = PARSE_HEADER;
  logic [8:0]   parse_pos   = '0;
  logic [7:0]   hdr_version = '0;
  logic [7:0]   hdr_opcode  = '0;
  logic [7:0]   hdr_seq     = '0;
  logic [15:0]  hdr_count   = '0;
  logic [15:0]  msgs_done   = '0;
  logic [31:0]  id_accum    = '0;
  logic [7:0]   msg_length  = '0;

  cuofp_pkg::out_item_t step_results[$];
  cuofp_pkg::out_item_t results_due[$];
  cuofp_pkg::out_item_t oldest_due;
  drill_row_t           drills[$];

  bit calm       = 1'b0;
  int live_items = 0;
  int mismatches = 0;
  int cycles     = 0;

  always #4 clk = ~clk;

  can_over_udp_frame_parser_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_stall_i (out_stall)
  );

  function automatic cuofp_pkg::out_item_t make_result(
    input cuofp_pkg::kind_e kind,
    input logic [7:0]       data,
    input logic             last,
    input logic [31:0]      id,
    input logic [7:0]       len,
    input logic [15:0]      idx,
    input logic [7:0]       ver,
    input logic [7:0]       opc,
    input logic [7:0]       seq,
    input logic [15:0]      cnt,
    input logic             err,
    input logic             run_last
  );
    cuofp_pkg::out_item_t r;
    r.kind            = kind;
    r.out_byte        = data;
    r.message_last    = last;
    r.frame_id        = id;
    r.payload_length  = len;
    r.message_index   = idx;
    r.version_field   = ver;
    r.opcode_field    = opc;
    r.sequence_number = seq;
    r.message_count   = cnt;
    r.error_code      = err;
    r.run_last        = run_last;
    return r;
  endfunction

  // Appends one result carrying the header bytes seen so far.
  task automatic emit(input cuofp_pkg::kind_e kind, input logic [7:0] data,
                      input logic last, input logic [31:0] id, input logic [7:0] len,
                      input logic [15:0] idx, input logic err);
    step_results.insert(step_results.size(),
                        make_result(kind, data, last, id, len, idx, hdr_version,
                                    hdr_opcode, hdr_seq, hdr_count, err, 1'b0));
  endtask

  // Advances the shadow parser by one byte and leaves its results in
  // step_results. Reports whether the byte was dropped in the skip phase.
  task automatic parse_byte(input cuofp_pkg::in_item_t stim, output bit dropped);
    logic [7:0]           data;
    logic                 eod;
    int unsigned          pos;
    bit                   last;
    cuofp_pkg::out_item_t tail;
    data    = stim.data_byte;
    eod     = stim.end_of_datagram;
    last    = 1'b0;
    dropped = 1'b0;
    step_results.delete();
    case (parse_phase)
      PARSE_HEADER: begin
        pos = (parse_pos > cuofp_pkg::HeaderBytes - 1) ?
              cuofp_pkg::HeaderBytes - 1 : parse_pos;
        // The first byte of a datagram wipes the previous header.
        case (pos)
          0: begin
            hdr_version = data;
            hdr_opcode  = '0;
            hdr_seq     = '0;
            hdr_count   = '0;
          end
          1: hdr_opcode = data;
          2: hdr_seq = data;
          3: hdr_count = {data, 8'h00};
          default: hdr_count[7:0] = data;
        endcase
        if (pos < cuofp_pkg::HeaderBytes - 1) begin
          if (eod) begin
            emit(cuofp_pkg::KIND_ERROR, 8'h00, 1'b0, '0, '0, '0, cuofp_pkg::ErrShort);
            parse_pos = '0;
          end else begin
            parse_pos = 9'(pos + 1);
          end
        end else begin
          emit(cuofp_pkg::KIND_HEADER, 8'h00, 1'b0, '0, '0, '0, 1'b0);
          msgs_done  = '0;
          id_accum   = '0;
          msg_length = '0;
          parse_pos  = '0;
          if (eod) parse_phase = PARSE_HEADER;
          else parse_phase = (hdr_count == 16'd0) ? PARSE_SKIP : PARSE_MESSAGE;
        end
      end
      PARSE_MESSAGE: begin
        pos = parse_pos;
        if (pos < IdBytes) begin
          // Identifier bytes are forwarded before the identifier is complete.
          id_accum = (pos == 0) ? {24'h0, data} : {id_accum[23:0], data};
          emit(cuofp_pkg::KIND_BYTE, data, 1'b0, '0, '0, msgs_done, 1'b0);
        end else begin
          if (pos == IdBytes) begin
            msg_length = data;
            last       = (data == 8'd0);
          end else begin
            last = (pos - IdBytes) >= msg_length;
          end
          emit(cuofp_pkg::KIND_BYTE, data, last, id_accum, msg_length, msgs_done, 1'b0);
        end
        if (eod && !last && pos >= IdBytes) begin
          emit(cuofp_pkg::KIND_ERROR, 8'h00, 1'b0, id_accum, msg_length, msgs_done,
               cuofp_pkg::ErrTrunc);
        end
        if (last) begin
          msgs_done = msgs_done + 16'd1;
          parse_pos = '0;
          if (msgs_done == hdr_count) parse_phase = PARSE_SKIP;
        end else begin
          parse_pos = 9'(pos + 1);
        end
        if (eod) begin
          parse_phase = PARSE_HEADER;
          parse_pos   = '0;
        end
      end
      default: begin
        dropped = 1'b1;
        if (eod) begin
          parse_phase = PARSE_HEADER;
          parse_pos   = '0;
        end
      end
    endcase
    if (step_results.size() > 0) begin
      tail          = step_results.pop_back();
      tail.run_last = 1'b1;
      step_results.insert(step_results.size(), tail);
    end
  endtask

  // Presents one item after a random gap, waits for it to be taken and
  // queues what it should produce.
  task automatic send_item(input cuofp_pkg::in_item_t stim, input bit pinned,
                           input cuofp_pkg::out_item_t want);
    bit dropped;
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= stim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(stim, dropped);
    if (pinned) begin
      results_due.insert(results_due.size(), want);
    end else begin
      foreach (step_results[i]) results_due.insert(results_due.size(), step_results[i]);
    end
    if (!dropped) live_items++;
    @(negedge clk);
  endtask

  task automatic add_drill(input logic [7:0] data, input logic eod, input bit pinned,
                           input cuofp_pkg::out_item_t want);
    drill_row_t row;
    row.stim.data_byte       = data;
    row.stim.end_of_datagram = eod;
    row.pinned               = pinned;
    row.want                 = want;
    drills.insert(drills.size(), row);
  endtask

  // Builds one datagram: mostly well-formed with random content, some cut
  // short, some with trailing bytes, and a share of short or random noise.
  task automatic send_random_datagram();
    logic [7:0]          dgram[$];
    cuofp_pkg::in_item_t stim;
    int unsigned         shape;
    int unsigned         count;
    int unsigned         msgs;
    int unsigned         len;
    int unsigned         pick;
    int unsigned         keep;
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      repeat ($urandom_range(1, 4)) dgram.insert(dgram.size(), 8'($urandom));
    end else if (shape < 12) begin
      repeat ($urandom_range(1, 12)) dgram.insert(dgram.size(), 8'($urandom));
    end else begin
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
      repeat (3) dgram.insert(dgram.size(), 8'($urandom));
      dgram.insert(dgram.size(), count[15:8]);
      dgram.insert(dgram.size(), count[7:0]);
      msgs = (count > 6) ? $urandom_range(0, 6) : count;
      for (int m = 0; m < msgs; m++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 8);
        else if (pick < 96) len = $urandom_range(9, 40);
        else len = 255;
        repeat (IdBytes) dgram.insert(dgram.size(), 8'($urandom));
        dgram.insert(dgram.size(), len[7:0]);
        repeat (len) dgram.insert(dgram.size(), 8'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 20 && dgram.size() > cuofp_pkg::HeaderBytes + 1) begin
        // End the datagram somewhere inside the messages.
        keep = $urandom_range(cuofp_pkg::HeaderBytes + 1, dgram.size() - 1);
        while (dgram.size() > keep) dgram.delete(dgram.size() - 1);
      end else if (pick < 35) begin
        repeat ($urandom_range(1, 4)) dgram.insert(dgram.size(), 8'($urandom));
      end
    end
    foreach (dgram[i]) begin
      stim.data_byte       = dgram[i];
      stim.end_of_datagram = (i == dgram.size() - 1);
      send_item(stim, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Output side stalls at random except during the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IdlePercent);
  end

  // Compares every accepted result with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result item with nothing expected: %0h", out_item);
        mismatches++;
      end else begin
        oldest_due = results_due.pop_front();
        check_field("kind", 32'(oldest_due.kind), 32'(out_item.kind));
        check_field("out_byte", 32'(oldest_due.out_byte), 32'(out_item.out_byte));
        check_field("message_last", 32'(oldest_due.message_last),
                    32'(out_item.message_last));
        check_field("frame_id", oldest_due.frame_id, out_item.frame_id);
        check_field("payload_length", 32'(oldest_due.payload_length),
                    32'(out_item.payload_length));
        check_field("message_index", 32'(oldest_due.message_index),
                    32'(out_item.message_index));
        check_field("version_field", 32'(oldest_due.version_field),
                    32'(out_item.version_field));
        check_field("opcode_field", 32'(oldest_due.opcode_field),
                    32'(out_item.opcode_field));
        check_field("sequence_number", 32'(oldest_due.sequence_number),
                    32'(out_item.sequence_number));
        check_field("message_count", 32'(oldest_due.message_count),
                    32'(out_item.message_count));
        check_field("error_code", 32'(oldest_due.error_code), 32'(out_item.error_code));
        check_field("run_last", 32'(oldest_due.run_last), 32'(out_item.run_last));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    // Short datagram straight after reset.
    add_drill(8'hFF, 1'b1, 1'b1,
              make_result(cuofp_pkg::KIND_ERROR, 8'h00, 1'b0, 32'h0, 8'h00, 16'h0000,
                          8'hFF, 8'h00, 8'h00, 16'h0000, cuofp_pkg::ErrShort, 1'b1));
    // Header only, with the largest message count.
    add_drill(8'h00, 1'b0, 1'b0, '0);
    add_drill(8'hFF, 1'b0, 1'b0, '0);
    add_drill(8'h80, 1'b0, 1'b0, '0);
    add_drill(8'hFF, 1'b0, 1'b0, '0);
    add_drill(8'hFF, 1'b1, 1'b1,
              make_result(cuofp_pkg::KIND_HEADER, 8'h00, 1'b0, 32'h0, 8'h00, 16'h0000,
                          8'h00, 8'hFF, 8'h80, 16'hFFFF, 1'b0, 1'b1));
    // Two messages: an empty one, then a 255-byte one cut after one byte.
    add_drill(8'h10, 1'b0, 1'b0, '0);
    add_drill(8'h20, 1'b0, 1'b0, '0);
    add_drill(8'h30, 1'b0, 1'b0, '0);
    add_drill(8'h00, 1'b0, 1'b0, '0);
    add_drill(8'h02, 1'b0, 1'b1,
              make_result(cuofp_pkg::KIND_HEADER, 8'h00, 1'b0, 32'h0, 8'h00, 16'h0000,
                          8'h10, 8'h20, 8'h30, 16'h0002, 1'b0, 1'b1));
    add_drill(8'h12, 1'b0, 1'b0, '0);
    add_drill(8'h34, 1'b0, 1'b0, '0);
    add_drill(8'h56, 1'b0, 1'b0, '0);
    add_drill(8'h78, 1'b0, 1'b0, '0);
    add_drill(8'h00, 1'b0, 1'b1,
              make_result(cuofp_pkg::KIND_BYTE, 8'h00, 1'b1, 32'h12345678, 8'h00,
                          16'h0000, 8'h10, 8'h20, 8'h30, 16'h0002, 1'b0, 1'b1));
    add_drill(8'h80, 1'b0, 1'b0, '0);
    add_drill(8'h00, 1'b0, 1'b0, '0);
    add_drill(8'h00, 1'b0, 1'b0, '0);
    add_drill(8'h01, 1'b0, 1'b0, '0);
    add_drill(8'hFF, 1'b0, 1'b0, '0);
    add_drill(8'hC3, 1'b1, 1'b0, '0);
    // Zero count: the byte after the header is dropped.
    add_drill(8'h7F, 1'b0, 1'b0, '0);
    add_drill(8'h01, 1'b0, 1'b0, '0);
    add_drill(8'hFE, 1'b0, 1'b0, '0);
    add_drill(8'h00, 1'b0, 1'b0, '0);
    add_drill(8'h00, 1'b0, 1'b0, '0);
    add_drill(8'h9C, 1'b1, 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (drills[i]) send_item(drills[i].stim, drills[i].pinned, drills[i].want);

    while (live_items < LiveItems) begin
      calm = (live_items >= 500 && live_items < 800);
      send_random_datagram();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cuofp_pkg.sv
sv/cuofp_front.sv
sv/cuofp_queue.sv
sv/cuofp_back.sv
sv/can_over_udp_frame_parser_unit.sv
verif/testbench.sv
